/* hdl/i2cms_pkg.sv */
package i2cms_pkg;

  // command and tick codes of one request
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } opcode_e;

  localparam int unsigned PhaseW = 5;
  localparam int unsigned TickW  = 16;

  // one input request as held in the input register
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic       sda_in;
  } item_t;

  // sequencer state
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic [2:0]        cmd;
    logic [PhaseW-1:0] phase;
    logic [TickW-1:0]  ticks;
    logic [7:0]        shift;
    logic              ack;
    logic [7:0]        read_hold;
    logic              sack_level;
  } state_t;

  // one result request
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;
  } result_t;

endpackage

/* hdl/i2cms_if.sv */
// input request channel
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       ack_bit;
  logic       sda_in;

  modport source(output valid, output opcode, output data_byte, output ack_bit,
                 output sda_in, input ready);
  modport sink(input valid, input opcode, input data_byte, input ack_bit,
               input sda_in, output ready);
endinterface

// result request channel
interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       rejected;

  modport source(output valid, output scl_level, output sda_level, output busy_res,
                 output done_res, output read_data, output ack_seen,
                 output rejected, input ready);
  modport sink(input valid, input scl_level, input sda_level, input busy_res,
               input done_res, input read_data, input ack_seen, input rejected,
               output ready);
endinterface

// phase length write channel
interface i2cms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/i2cms_step.sv */
module i2cms_step (
  input  i2cms_pkg::state_t  state_i,
  input  i2cms_pkg::item_t   item_i,
  input  logic [15:0]        phase_ticks_i,
  output i2cms_pkg::state_t  state_o,
  output i2cms_pkg::result_t res_o
);
  import i2cms_pkg::*;

  // number of phases in each command sequence
  function automatic logic [PhaseW-1:0] seq_len(input logic [2:0] cmd);
    logic [PhaseW-1:0] len;
    case (opcode_e'(cmd))
      OP_START: len = PhaseW'(4);
      OP_STOP:  len = PhaseW'(3);
      OP_WRITE: len = PhaseW'(24);
      OP_READ:  len = PhaseW'(17);
      OP_SACK:  len = PhaseW'(3);
      OP_RACK:  len = PhaseW'(3);
      default:  len = '0;
    endcase
    return len;
  endfunction

  // line levels for phase idx of cmd, returned as {scl, sda}
  function automatic logic [1:0] drive(input logic [2:0] cmd, input logic [PhaseW-1:0] idx,
                                       input logic [7:0] shift, input logic sack,
                                       input logic scl, input logic sda);
    logic             scl_n;
    logic             sda_n;
    logic [2:0]       bsel;
    logic [PhaseW-1:0] sub;
    scl_n = scl;
    sda_n = sda;
    // bit number and step within a write bit, idx split by three
    bsel = '0;
    for (int i = 1; i < 8; i++) begin
      if (idx >= PhaseW'(3 * i)) bsel = 3'(i);
    end
    sub = idx - {1'b0, bsel, 1'b0} - {2'b00, bsel};
    case (opcode_e'(cmd))
      OP_START: begin
        if (idx == PhaseW'(0)) sda_n = 1'b1;
        else if (idx == PhaseW'(1)) scl_n = 1'b1;
        else if (idx == PhaseW'(2)) sda_n = 1'b0;
        else scl_n = 1'b0;
      end
      OP_STOP: begin
        if (idx == PhaseW'(0)) sda_n = 1'b0;
        else if (idx == PhaseW'(1)) scl_n = 1'b1;
        else sda_n = 1'b1;
      end
      OP_WRITE: begin
        if (sub == PhaseW'(0)) sda_n = shift[3'd7 - bsel];
        else if (sub == PhaseW'(1)) scl_n = 1'b1;
        else scl_n = 1'b0;
      end
      OP_READ: begin
        if (idx == PhaseW'(0)) sda_n = 1'b1;
        else if (idx[0]) scl_n = 1'b1;
        else scl_n = 1'b0;
      end
      OP_SACK: begin
        if (idx == PhaseW'(0)) sda_n = sack;
        else if (idx == PhaseW'(1)) scl_n = 1'b1;
        else scl_n = 1'b0;
      end
      OP_RACK: begin
        if (idx == PhaseW'(0)) sda_n = 1'b1;
        else if (idx == PhaseW'(1)) scl_n = 1'b1;
        else scl_n = 1'b0;
      end
      default: ;
    endcase
    return {scl_n, sda_n};
  endfunction

  logic [TickW-1:0]  limit;
  logic [TickW-1:0]  ticks_inc;
  logic [PhaseW-1:0] phase_inc;
  logic              done;
  logic              rej;
  state_t            nxt;

  assign limit     = (phase_ticks_i == '0) ? TickW'(1) : phase_ticks_i;
  assign ticks_inc = state_i.ticks + TickW'(1);
  assign phase_inc = state_i.phase + PhaseW'(1);

  // next state for one request
  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    rej  = 1'b0;
    case (item_i.opcode) inside
      OP_TICK: begin
        if (state_i.cmd != '0) begin
          nxt.ticks = ticks_inc;
          if (ticks_inc >= limit) begin
            // sample at the end of an scl-high phase
            if (opcode_e'(state_i.cmd) == OP_READ && state_i.phase[0]) begin
              nxt.shift = {state_i.shift[6:0], item_i.sda_in};
            end else if (opcode_e'(state_i.cmd) == OP_RACK &&
                         state_i.phase == PhaseW'(1)) begin
              nxt.ack = item_i.sda_in;
            end
            nxt.ticks = '0;
            if (phase_inc >= seq_len(state_i.cmd)) begin
              if (opcode_e'(state_i.cmd) == OP_READ) nxt.read_hold = nxt.shift;
              nxt.cmd   = '0;
              nxt.phase = '0;
              done      = 1'b1;
            end else begin
              nxt.phase = phase_inc;
              {nxt.scl, nxt.sda} = drive(state_i.cmd, phase_inc, nxt.shift,
                                         state_i.sack_level, state_i.scl, state_i.sda);
            end
          end
        end
      end
      [OP_START:OP_RACK]: begin
        if (state_i.cmd != '0) begin
          rej = 1'b1;
        end else begin
          nxt.cmd   = item_i.opcode;
          nxt.phase = '0;
          nxt.ticks = '0;
          if (opcode_e'(item_i.opcode) == OP_WRITE) nxt.shift = item_i.data_byte;
          else if (opcode_e'(item_i.opcode) == OP_READ) nxt.shift = '0;
          if (opcode_e'(item_i.opcode) == OP_SACK) nxt.sack_level = item_i.ack_bit;
          {nxt.scl, nxt.sda} = drive(item_i.opcode, '0, nxt.shift, nxt.sack_level,
                                     state_i.scl, state_i.sda);
        end
      end
      default: ;
    endcase
  end

  assign state_o = nxt;

  // result fields
  always_comb begin
    res_o.scl_level = nxt.scl;
    res_o.sda_level = nxt.sda;
    res_o.busy_res  = (nxt.cmd != '0);
    res_o.done_res  = done;
    res_o.read_data = nxt.read_hold;
    res_o.ack_seen  = nxt.ack;
    res_o.rejected  = rej;
  end

endmodule

/* hdl/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer: one result per request, ticks and commands alike.
// Path: a request is captured in the input register; as it leaves that register,
// the state update and the result register load together and result valid is set.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset: asynchronous active low; lines released, idle, phase length 1.
module i2c_master_bit_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cms_in_if.sink    in_i,
  i2cms_cfg_if.sink   cfg_i,
  i2cms_out_if.source out_o
);
  import i2cms_pkg::*;

  logic        in_valid_q;
  item_t       in_item_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res_d;
  state_t      state_q;
  state_t      state_d;
  logic [15:0] phase_ticks_q;
  logic        advance;
  logic        in_accept;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // phase length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd1;
    end else if (cfg_i.valid) begin
      phase_ticks_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= '{opcode: in_i.opcode, data_byte: in_i.data_byte,
                     ack_bit: in_i.ack_bit, sda_in: in_i.sda_in};
    end
  end

  i2cms_step u_step (
    .state_i      (state_q),
    .item_i       (in_item_q),
    .phase_ticks_i(phase_ticks_q),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  // sequencer state, updated as each request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{scl: 1'b1, sda: 1'b1, default: '0};
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_valid_q && advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.scl_level = res_q.scl_level;
  assign out_o.sda_level = res_q.sda_level;
  assign out_o.busy_res  = res_q.busy_res;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.read_data = res_q.read_data;
  assign out_o.ack_seen  = res_q.ack_seen;
  assign out_o.rejected  = res_q.rejected;

endmodule
